/* rtl/gmt_pkg.sv */
// Shared constants and types of the gossip membership table unit.
// Used by the top level and by its port checker; depends on nothing.
package gmt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PICK_W      = 16;
  localparam int TGT_W       = 5;
  localparam int STEP_W      = $clog2(PICK_W);

  // Command codes.
  localparam logic [1:0] CMD_GOSSIP     = 2'd0;
  localparam logic [1:0] CMD_JOIN_REPLY = 2'd1;
  localparam logic [1:0] CMD_JOIN_REQ   = 2'd2;
  localparam logic [1:0] CMD_TICK       = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_JOIN_REPLY = 2'd0;
  localparam logic [1:0] KIND_GOSSIP     = 2'd1;
  localparam logic [1:0] KIND_DROPPED    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SELF_ID       = 2'd0;
  localparam logic [1:0] CFG_SELF_PORT     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT       = 2'd2;
  localparam logic [1:0] CFG_STARTS_JOINED = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] stamp;
  } entry_t;

endpackage

/* rtl/gossip_membership_table_unit.sv */
// Channel  | Signals                                     | Direction
// config   | cfg_valid_i/cfg_ready_o, cfg_index_i, data  | in
// request  | in_valid_i/in_ready_o, command_i .. eom     | in
// result   | out_valid_o/out_ready_i, kind_o .. last_o   | out
//
// One request at a time. A table scan (gossip merge, tick refresh and
// compaction) reads one entry per cycle from the table memory, which has separate
// read and write ports. A tick then reduces random_pick modulo the new count in a
// bit-serial remainder unit and emits each surviving entry. A join request gives one
// result; a join reply appends self, then the sender, dropping an append when full.
// Results wait in the output register; a stall holds the sequencer in place.
// Reset clears the count, own heartbeat and joined; table entries are not cleared.
// Depends on gmt_pkg.
module gossip_membership_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] node_id_i,
  input  logic [15:0] node_port_i,
  input  logic [31:0] node_heartbeat_i,
  input  logic [31:0] current_time_i,
  input  logic [15:0] random_pick_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [4:0]  target_index_o,
  output logic [31:0] dest_id_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] out_id_o,
  output logic [15:0] out_port_o,
  output logic [31:0] out_heartbeat_o,
  output logic [31:0] out_stamp_o,
  output logic        last_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GSCAN = 4'd1;
  localparam logic [3:0] S_APP1  = 4'd2;
  localparam logic [3:0] S_APP2  = 4'd3;
  localparam logic [3:0] S_TSCAN = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_ELD   = 4'd6;
  localparam logic [3:0] S_EWAIT = 4'd7;
  localparam logic [3:0] S_OWAIT = 4'd8;

  localparam int CW = gmt_pkg::CNT_W;

  logic [3:0]    state_q, state_d, ret_q, ret_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, wr_q, wr_d, rem_q, rem_d;
  logic [gmt_pkg::STEP_W-1:0] step_q, step_d;
  logic          found_q, found_d, vld_q, vld_d;
  logic [31:0]   own_hb_q, own_hb_d;
  logic          joined_q, joined_d;
  logic [31:0]   self_id_q, self_id_d;
  logic [15:0]   self_port_q, self_port_d, timeout_q, timeout_d;
  logic [31:0]   nid_q, nid_d, nhb_q, nhb_d, now_q, now_d;
  logic [15:0]   nport_q, nport_d;
  logic [gmt_pkg::PICK_W-1:0] pick_q, pick_d;

  logic          ov_q, ov_d, olast_q, olast_d;
  logic [1:0]    kind_q, kind_d;
  logic [4:0]    tgt_q, tgt_d;
  logic [31:0]   did_q, did_d;
  logic [15:0]   dport_q, dport_d;
  gmt_pkg::entry_t oent_q, oent_d;

  gmt_pkg::entry_t mem_q [gmt_pkg::TABLE_DEPTH];
  gmt_pkg::entry_t rd_q, wdata, e;
  logic          we, re;
  logic [CW-1:0] waddr, raddr;
  logic [CW-1:0] rd_idx;
  logic          hit, in_acc;
  logic [31:0]   age;
  logic [CW:0]   shifted;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign rd_idx      = idx_q - CW'(1);
  assign hit         = vld_q && rd_q.id == nid_q && rd_q.port == nport_q;

  always_comb begin
    state_d = state_q;  ret_d = ret_q;
    cnt_d = cnt_q;  idx_d = idx_q;  wr_d = wr_q;  rem_d = rem_q;  step_d = step_q;
    found_d = found_q;  vld_d = 1'b0;  own_hb_d = own_hb_q;  joined_d = joined_q;
    self_id_d = self_id_q;  self_port_d = self_port_q;  timeout_d = timeout_q;
    nid_d = nid_q;  nport_d = nport_q;  nhb_d = nhb_q;  now_d = now_q;  pick_d = pick_q;
    ov_d = ov_q;  olast_d = olast_q;  kind_d = kind_q;  tgt_d = tgt_q;
    did_d = did_q;  dport_d = dport_q;  oent_d = oent_q;
    we = 1'b0;  waddr = wr_q;  wdata = rd_q;  re = 1'b0;  raddr = idx_q;
    e = rd_q;  age = '0;  shifted = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        gmt_pkg::CFG_SELF_ID:       self_id_d = cfg_data_i;
        gmt_pkg::CFG_SELF_PORT:     self_port_d = cfg_data_i[15:0];
        gmt_pkg::CFG_TIMEOUT:       timeout_d = cfg_data_i[15:0];
        gmt_pkg::CFG_STARTS_JOINED: joined_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          nid_d = node_id_i;  nport_d = node_port_i;  nhb_d = node_heartbeat_i;
          now_d = current_time_i;  pick_d = random_pick_i;
          idx_d = '0;  wr_d = '0;  found_d = 1'b0;
          case (command_i)
            gmt_pkg::CMD_GOSSIP: if (joined_q) state_d = S_GSCAN;
            gmt_pkg::CMD_JOIN_REPLY: begin
              if (!joined_q) begin
                joined_d = 1'b1;
                state_d  = S_APP1;
              end
            end
            gmt_pkg::CMD_JOIN_REQ: begin
              if (joined_q) begin
                ov_d = 1'b1;  olast_d = 1'b1;  kind_d = gmt_pkg::KIND_JOIN_REPLY;
                tgt_d = '0;  did_d = node_id_i;  dport_d = node_port_i;
                oent_d = '{id: self_id_q, port: self_port_q, hb: own_hb_q, stamp: 32'd0};
                ret_d = S_IDLE;  state_d = S_OWAIT;
              end
            end
            gmt_pkg::CMD_TICK: begin
              if (joined_q) begin
                own_hb_d = own_hb_q + 32'd1;
                state_d  = S_TSCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_GSCAN: begin
        re = (idx_q < cnt_q) && !hit;
        vld_d = re;
        if (re) idx_d = idx_q + CW'(1);
        if (hit) begin
          if (nhb_q > rd_q.hb) begin
            we = 1'b1;  waddr = rd_idx;
            wdata = '{id: rd_q.id, port: rd_q.port, hb: nhb_q, stamp: now_q};
          end
          state_d = S_IDLE;
        end else if (!vld_q && idx_q >= cnt_q) begin
          state_d = S_APP2;
        end
      end
      S_APP1, S_APP2: begin
        if (state_q == S_APP1) begin
          e = '{id: self_id_q, port: self_port_q, hb: own_hb_q, stamp: now_q};
        end else begin
          e = '{id: nid_q, port: nport_q, hb: nhb_q, stamp: now_q};
        end
        if (cnt_q < CW'(gmt_pkg::TABLE_DEPTH)) begin
          we = 1'b1;  waddr = cnt_q;  wdata = e;
          cnt_d = cnt_q + CW'(1);
          state_d = (state_q == S_APP1) ? S_APP2 : S_IDLE;
        end else begin
          // Full table: the dropped entry goes out as a result.
          ov_d = 1'b1;  olast_d = (state_q == S_APP2);  kind_d = gmt_pkg::KIND_DROPPED;
          tgt_d = '0;  did_d = '0;  dport_d = '0;  oent_d = e;
          ret_d = (state_q == S_APP1) ? S_APP2 : S_IDLE;
          state_d = S_OWAIT;
        end
      end
      S_TSCAN: begin
        re = idx_q < cnt_q;
        vld_d = re;
        if (re) idx_d = idx_q + CW'(1);
        if (vld_q) begin
          if (!found_q && rd_q.id == self_id_q && rd_q.port == self_port_q) begin
            e.hb = own_hb_q;  e.stamp = now_q;  found_d = 1'b1;
          end
          age = now_q - e.stamp;
          // Surviving entries are written back down at the write pointer.
          if (age <= {16'd0, timeout_q}) begin
            we = 1'b1;  waddr = wr_q;  wdata = e;
            wr_d = wr_q + CW'(1);
          end
        end else if (idx_q >= cnt_q) begin
          cnt_d = wr_q;  rem_d = '0;  step_d = '0;
          state_d = (wr_q == '0) ? S_IDLE : S_DIV;
        end
      end
      S_DIV: begin
        // Restoring remainder, one bit of random_pick per cycle.
        shifted = {rem_q, pick_q[gmt_pkg::PICK_W-1]};
        if (shifted >= {1'b0, cnt_q}) shifted = shifted - {1'b0, cnt_q};
        rem_d  = shifted[CW-1:0];
        pick_d = pick_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == gmt_pkg::STEP_W'(gmt_pkg::PICK_W - 1)) begin
          re = 1'b1;  raddr = '0;  idx_d = '0;
          state_d = S_ELD;
        end
      end
      S_ELD: begin
        ov_d = 1'b1;  olast_d = (idx_q == cnt_q - CW'(1));  kind_d = gmt_pkg::KIND_GOSSIP;
        tgt_d = rem_q[gmt_pkg::TGT_W-1:0];  did_d = '0;  dport_d = '0;  oent_d = rd_q;
        state_d = S_EWAIT;
      end
      S_EWAIT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (olast_q) begin
            state_d = S_IDLE;
          end else begin
            re = 1'b1;  raddr = idx_q + CW'(1);  idx_d = idx_q + CW'(1);
            state_d = S_ELD;
          end
        end
      end
      S_OWAIT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  ret_q <= S_IDLE;
      cnt_q <= '0;  idx_q <= '0;  wr_q <= '0;  step_q <= '0;
      found_q <= 1'b0;  vld_q <= 1'b0;  own_hb_q <= '0;  joined_q <= 1'b0;
      self_id_q <= '0;  self_port_q <= '0;  timeout_q <= 16'd20;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;  ret_q <= ret_d;
      cnt_q <= cnt_d;  idx_q <= idx_d;  wr_q <= wr_d;  step_q <= step_d;
      found_q <= found_d;  vld_q <= vld_d;  own_hb_q <= own_hb_d;  joined_q <= joined_d;
      self_id_q <= self_id_d;  self_port_q <= self_port_d;  timeout_q <= timeout_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;  pick_q <= pick_d;
    nid_q <= nid_d;  nport_q <= nport_d;  nhb_q <= nhb_d;  now_q <= now_d;
    olast_q <= olast_d;  kind_q <= kind_d;  tgt_q <= tgt_d;
    did_q <= did_d;  dport_q <= dport_d;  oent_q <= oent_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr[gmt_pkg::IDX_W-1:0]] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rd_q <= mem_q[raddr[gmt_pkg::IDX_W-1:0]];
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = kind_q;
  assign target_index_o  = tgt_q;
  assign dest_id_o       = did_q;
  assign dest_port_o     = dport_q;
  assign out_id_o        = oent_q.id;
  assign out_port_o      = oent_q.port;
  assign out_heartbeat_o = oent_q.hb;
  assign out_stamp_o     = oent_q.stamp;
  assign last_o          = olast_q;

endmodule

/* rtl/gmt_checker.sv */
// Port-level checks for the gossip membership table unit, bound to the top level.
// Depends on gmt_pkg.
module gmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [4:0]  target_index_o,
  input logic [31:0] dest_id_o,
  input logic [31:0] out_stamp_o,
  input logic [31:0] out_id_o,
  input logic        last_o
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_id_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A new request is never taken while a result is still pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request accepted with a result pending");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= gmt_pkg::KIND_DROPPED)
    else $error("illegal result kind");

  // A join reply is always the single, final result of its request.
  a_join_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == gmt_pkg::KIND_JOIN_REPLY |-> last_o && out_stamp_o == 32'd0)
    else $error("malformed join reply");

  a_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == gmt_pkg::KIND_DROPPED |-> target_index_o == 5'd0
      && dest_id_o == 32'd0)
    else $error("malformed dropped-append result");

endmodule

bind gossip_membership_table_unit gmt_checker u_gmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .target_index_o (target_index_o),
  .dest_id_o      (dest_id_o),
  .out_stamp_o    (out_stamp_o),
  .out_id_o       (out_id_o),
  .last_o         (last_o)
);

/* dv/gossip_membership_table_unit_tb.sv */
// Testbench for the gossip membership table unit: directed and random requests,
// checked against a behavioral copy of the membership table kept in a scoreboard.
// Depends on gmt_pkg and the gossip_membership_table_unit RTL.
`timescale 1ns / 100ps

module gossip_membership_table_unit_tb;

  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  tgt;
    logic [31:0] did;
    logic [15:0] dport;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] stamp;
    logic        last;
  } result_t;

  class membership_scoreboard;
    logic [31:0] self_id;
    logic [15:0] self_port;
    logic [15:0] timeout;
    bit          joined;
    gmt_pkg::entry_t table_q[$];
    logic [31:0] own_hb;
    result_t     pending[$];
    int          errors;
    int          n_checked;

    function void clear();
      self_id = '0;
      self_port = '0;
      timeout = 16'd20;
      joined = 0;
      table_q.delete();
      own_hb = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        gmt_pkg::CFG_SELF_ID:       self_id = data;
        gmt_pkg::CFG_SELF_PORT:     self_port = data[15:0];
        gmt_pkg::CFG_TIMEOUT:       timeout = data[15:0];
        gmt_pkg::CFG_STARTS_JOINED: joined = data[0];
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] k, logic [4:0] t, logic [31:0] did, logic [15:0] dp,
                       logic [31:0] id, logic [15:0] p, logic [31:0] hb, logic [31:0] st);
      result_t r;
      r = '{k, t, did, dp, id, p, hb, st, 1'b0};
      pending.insert(pending.size(), r);
    endfunction

    function void add_member(logic [31:0] id, logic [15:0] p, logic [31:0] hb,
                             logic [31:0] now);
      gmt_pkg::entry_t e;
      if (table_q.size() < gmt_pkg::TABLE_DEPTH) begin
        e = '{id, p, hb, now};
        table_q.insert(table_q.size(), e);
      end else begin
        push(gmt_pkg::KIND_DROPPED, '0, '0, '0, id, p, hb, now);
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic [31:0] nid, logic [15:0] np,
                               logic [31:0] nhb, logic [31:0] now, logic [15:0] pick);
      int n_prior;
      bit found;
      gmt_pkg::entry_t kept[$];
      logic [4:0] tgt;
      n_prior = pending.size();
      found = 0;
      case (cmd)
        gmt_pkg::CMD_GOSSIP: if (joined) begin
          foreach (table_q[i])
            if (!found && table_q[i].id == nid && table_q[i].port == np) begin
              found = 1;
              if (nhb > table_q[i].hb) begin
                table_q[i].hb = nhb;
                table_q[i].stamp = now;
              end
            end
          if (!found) add_member(nid, np, nhb, now);
        end
        gmt_pkg::CMD_JOIN_REPLY: if (!joined) begin
          joined = 1;
          add_member(self_id, self_port, own_hb, now);
          add_member(nid, np, nhb, now);
        end
        gmt_pkg::CMD_JOIN_REQ: if (joined)
          push(gmt_pkg::KIND_JOIN_REPLY, '0, nid, np, self_id, self_port, own_hb, '0);
        default: if (joined) begin
          own_hb = own_hb + 1;
          foreach (table_q[i])
            if (!found && table_q[i].id == self_id && table_q[i].port == self_port) begin
              found = 1;
              table_q[i].hb = own_hb;
              table_q[i].stamp = now;
            end
          foreach (table_q[i])
            if (now - table_q[i].stamp <= {16'd0, timeout})
              kept.insert(kept.size(), table_q[i]);
          table_q = kept;
          if (table_q.size() > 0) begin
            tgt = 5'(pick % table_q.size());
            foreach (table_q[i])
              push(gmt_pkg::KIND_GOSSIP, tgt, '0, '0, table_q[i].id, table_q[i].port,
                   table_q[i].hb, table_q[i].stamp);
          end
        end
      endcase
      if (pending.size() > n_prior) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing expected: kind %0d id %h", got.kind, got.id);
        errors++;
        return;
      end
      exp = pending.pop_front();
      n_checked++;
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind); errors++;
      end
      if (got.tgt !== exp.tgt) begin
        $error("target_index: expected %0d, got %0d", exp.tgt, got.tgt); errors++;
      end
      if (got.did !== exp.did) begin
        $error("dest_id: expected %h, got %h", exp.did, got.did); errors++;
      end
      if (got.dport !== exp.dport) begin
        $error("dest_port: expected %h, got %h", exp.dport, got.dport); errors++;
      end
      if (got.id !== exp.id) begin
        $error("out_id: expected %h, got %h", exp.id, got.id); errors++;
      end
      if (got.port !== exp.port) begin
        $error("out_port: expected %h, got %h", exp.port, got.port); errors++;
      end
      if (got.hb !== exp.hb) begin
        $error("out_heartbeat: expected %h, got %h", exp.hb, got.hb); errors++;
      end
      if (got.stamp !== exp.stamp) begin
        $error("out_stamp: expected %h, got %h", exp.stamp, got.stamp); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [31:0] node_id_i = '0;
  logic [15:0] node_port_i = '0;
  logic [31:0] node_heartbeat_i = '0;
  logic [31:0] current_time_i = '0;
  logic [15:0] random_pick_i = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [4:0]  target_index_o;
  logic [31:0] dest_id_o;
  logic [15:0] dest_port_o;
  logic [31:0] out_id_o;
  logic [15:0] out_port_o;
  logic [31:0] out_heartbeat_o;
  logic [31:0] out_stamp_o;
  logic        last_o;

  gossip_membership_table_unit u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  membership_scoreboard sb = new();
  logic [31:0] now_q;
  int          n_requests;
  int          hold_off;
  int          idle_cycles;
  bit          stall_mode;
  logic [31:0] peers_id[8];
  logic [15:0] peers_port[8];

  // Receiver: a random stall pattern, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (stall_mode) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready_i <= 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{kind_o, target_index_o, dest_id_o, dest_port_o, out_id_o,
                        out_port_o, out_heartbeat_o, out_stamp_o, last_o});
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic [1:0] cmd, logic [31:0] nid, logic [15:0] np,
                      logic [31:0] nhb, logic [31:0] now, logic [15:0] pick);
    command_i <= cmd;
    node_id_i <= nid;
    node_port_i <= np;
    node_heartbeat_i <= nhb;
    current_time_i <= now;
    random_pick_i <= pick;
    end_of_message_i <= $urandom_range(0, 1);
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, nid, np, nhb, now, pick);
    n_requests++;
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for every expected result, then for the tail of the block's work.
  task automatic drain();
    pause_sender();
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    int burst;
    int r;
    logic [1:0] cmd;
    int p;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        repeat ($urandom_range(0, 6)) pause_sender();
      end
      burst--;
      now_q = now_q + $urandom_range(0, 6);
      r = $urandom_range(0, 99);
      cmd = r < 55 ? gmt_pkg::CMD_GOSSIP : r < 60 ? gmt_pkg::CMD_JOIN_REPLY :
            r < 75 ? gmt_pkg::CMD_JOIN_REQ : gmt_pkg::CMD_TICK;
      p = $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0)
        send(cmd, $urandom, 16'($urandom), $urandom, $urandom, 16'($urandom));
      else
        send(cmd, peers_id[p], peers_port[p], now_q + $urandom_range(0, 20),
             now_q, 16'($urandom));
    end
  endtask

  initial begin
    hold_off = 0;
    idle_cycles = 0;
    stall_mode = 0;
    now_q = '0;
    n_requests = 0;
    sb.clear();
    foreach (peers_id[i]) begin
      peers_id[i] = $urandom;
      peers_port[i] = 16'($urandom);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Commands while not joined are ignored; then join and exercise extremes.
    send(gmt_pkg::CMD_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, '0);
    send(gmt_pkg::CMD_JOIN_REQ, 32'h1, 16'h2, '0, '0, '0);
    send(gmt_pkg::CMD_TICK, '0, '0, '0, '0, 16'hFFFF);
    send(gmt_pkg::CMD_JOIN_REPLY, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd5, '0);
    send(gmt_pkg::CMD_JOIN_REPLY, '0, '0, '0, 32'd5, '0);
    send(gmt_pkg::CMD_JOIN_REQ, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, '0);
    send(gmt_pkg::CMD_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'd6, '0);
    send(gmt_pkg::CMD_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd7, '0);
    send(gmt_pkg::CMD_GOSSIP, 32'hAAAA_5555, 16'h5A5A, 32'h10, 32'd8, '0);
    send(gmt_pkg::CMD_TICK, '0, '0, '0, 32'd20, 16'hFFFF);
    // Entries older than the timeout drop out; stamp 5 is exactly 20 old here.
    send(gmt_pkg::CMD_TICK, '0, '0, '0, 32'd25, 16'd3);
    send(gmt_pkg::CMD_TICK, '0, '0, '0, 32'hFFFF_FFF0, 16'd7);
    drain();

    write_reg(gmt_pkg::CFG_SELF_ID, 32'hFFFF_FFFF);
    write_reg(gmt_pkg::CFG_SELF_PORT, 32'h0000_FFFF);
    write_reg(gmt_pkg::CFG_TIMEOUT, 32'h0000_FFFF);
    write_reg(gmt_pkg::CFG_STARTS_JOINED, 32'h1);
    // Fill the table past its depth, then join again with a full table.
    for (int i = 0; i < 36; i++)
      send(gmt_pkg::CMD_GOSSIP, 32'h100 + i, 16'(i), 32'd1, 32'h7FFF_FFF0 + i, '0);
    send(gmt_pkg::CMD_TICK, '0, '0, '0, 32'h8000_0000, 16'd31);
    drain();
    write_reg(gmt_pkg::CFG_STARTS_JOINED, 32'h0);
    send(gmt_pkg::CMD_JOIN_REPLY, 32'h55, 16'h66, 32'h77, 32'h8000_0001, '0);
    send(gmt_pkg::CMD_TICK, '0, '0, '0, 32'h8000_0002, 16'hFFFF);
    drain();

    // Long receiver hold-off while requests keep coming.
    write_reg(gmt_pkg::CFG_TIMEOUT, 32'h0);
    write_reg(gmt_pkg::CFG_SELF_ID, $urandom);
    write_reg(gmt_pkg::CFG_SELF_PORT, $urandom);
    stall_mode = 1;
    hold_off = 400;
    random_phase(50);
    drain();

    write_reg(gmt_pkg::CFG_TIMEOUT, 32'd30);
    write_reg(gmt_pkg::CFG_STARTS_JOINED, 32'h1);
    random_phase(50);
    drain();

    stall_mode = 0;
    write_reg(gmt_pkg::CFG_TIMEOUT, 32'd12);
    write_reg(gmt_pkg::CFG_STARTS_JOINED, 32'h0);
    random_phase(50);
    drain();

    $display("Covered %0d requests and %0d results over several register settings,",
             n_requests, sb.n_checked);
    $display("including full-table drops, timeouts, joins and receiver back-pressure.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/gmt_pkg.sv
rtl/gossip_membership_table_unit.sv
rtl/gmt_checker.sv
dv/gossip_membership_table_unit_tb.sv
